[src/fvrgb_pkg.sv]
// Shared constants and tables for the flow vector to RGB color unit.
`default_nettype none
package fvrgb_pkg;

  localparam int MD_W     = 11;              // max_disp register width
  localparam int MDSQ_W   = 2 * MD_W;        // squared normalizer width
  localparam int SAT_SH   = 19;              // saturation numerator shift
  localparam int Q16_W    = 17;              // Q16 value up to and including 1.0
  localparam int DIV_BITS = 17;              // quotient bits below the clamp point
  localparam int PRE_SH   = 24;              // CORDIC input prescale
  localparam int ANG_W    = 32;              // hue as a fraction of one turn
  localparam int ATAN_LEN = 24;

  localparam logic [Q16_W-1:0] Q16_ONE = 17'd65536;
  localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [MD_W-1:0]  MAX_DISP_RST = 11'd64;

  // register indexes
  localparam logic REG_MAX_DISP = 1'b0;

  // sector codes of the six-sector conversion
  localparam logic [2:0] SEC_RY = 3'd0;
  localparam logic [2:0] SEC_YG = 3'd1;
  localparam logic [2:0] SEC_GC = 3'd2;
  localparam logic [2:0] SEC_CB = 3'd3;
  localparam logic [2:0] SEC_BM = 3'd4;

  // atan(2^-i) as a 32-bit fraction of a full turn
  localparam logic [ANG_W-1:0] TURN_ATAN [0:ATAN_LEN-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

endpackage
`default_nettype wire

[src/flow_vector_to_rgb_color_unit.sv]
// Top level: pipelined flow vector to RGB color coder.
//
//  channel | ports                                         | dir | handshake
//  --------+-----------------------------------------------+-----+-----------------
//  in      | in_flow_u, in_flow_v, in_pixel_valid          | in  | in_valid/in_ready
//  out     | out_red, out_green, out_blue                  | out | out_valid/out_ready
//  cfg     | cfg_psel..cfg_pwdata, cfg_prdata, cfg_pready  | in  | APB read/write, no wait
//
// One item per clock while the output stage is taken. The path runs from
// acceptance through the square root (one result bit per stage) followed by the
// saturation divider (one quotient bit per stage); the hue CORDIC runs
// alongside and is delayed to meet it. Reset (rst_n low, synchronous) empties
// the pipeline and loads max_disp with 64. The whole pipeline advances
// together: it holds when the output stage is full and not taken.
`default_nettype none
module flow_vector_to_rgb_color_unit
  import fvrgb_pkg::*;
#(
  parameter int FLOW_WIDTH     = 18,
  parameter int FLOW_FRAC_BITS = 6,
  parameter int CORDIC_STAGES  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FLOW_WIDTH-1:0] in_flow_u,
  input  wire logic [FLOW_WIDTH-1:0] in_flow_v,
  input  wire logic                  in_pixel_valid,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_blue,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [2:0]            cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  localparam int FW    = FLOW_WIDTH;
  localparam int CS    = CORDIC_STAGES;
  localparam int RADW  = 2 * FW;
  localparam int REMW  = FW + 2;
  localparam int SH    = SAT_SH - FLOW_FRAC_BITS;
  localparam int NW    = FW + SAT_SH;
  localparam int DVW   = ((NW > MDSQ_W + DIV_BITS) ? NW : MDSQ_W + DIV_BITS) + 1;
  localparam int CW    = FW + PRE_SH + 3;
  localparam int SQ    = 20 + FW;                  // stage holding the quotient
  localparam int DH    = SQ - (2 + CS);            // hue delay to meet it
  localparam int LAST  = SQ + 2;                   // output stage

  // ---------------------------------------------------------------- config
  logic [MD_W-1:0]   max_disp_r, max_disp_nxt;
  logic [MDSQ_W-1:0] mdsq_r, mdsq_nxt;
  logic [MD_W-1:0]   md_eff;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_DISP) ? {21'd0, max_disp_r} : 32'd0;

  always_comb begin
    max_disp_nxt = max_disp_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_MAX_DISP) begin
      max_disp_nxt = cfg_pwdata[MD_W-1:0];
    end
    // zero acts as one
    md_eff   = (max_disp_r == '0) ? MD_W'(1) : max_disp_r;
    mdsq_nxt = MDSQ_W'(md_eff) * MDSQ_W'(md_eff);
  end

  // ---------------------------------------------------------------- pipeline
  logic adv;
  logic vld_r [0:LAST];
  logic pv_r  [0:LAST];

  logic signed [FW-1:0] u0_r, v0_r;
  logic [RADW-1:0]      usq_r, vsq_r, usq_nxt, vsq_nxt;
  logic signed [RADW-1:0] usq_s, vsq_s;

  logic [RADW-1:0] is_rad_r [0:FW];
  logic [REMW-1:0] is_rem_r [0:FW];
  logic [FW-1:0]   is_q_r   [0:FW];
  logic [RADW-1:0] is_rad_nxt [0:FW];
  logic [REMW-1:0] is_rem_nxt [0:FW];
  logic [FW-1:0]   is_q_nxt   [0:FW];

  logic [DVW-1:0]   dv_rem_r [0:DIV_BITS];
  logic [Q16_W-1:0] dv_q_r   [0:DIV_BITS];
  logic             dv_cl_r  [0:DIV_BITS];
  logic [DVW-1:0]   dv_rem_nxt [0:DIV_BITS];
  logic [Q16_W-1:0] dv_q_nxt   [0:DIV_BITS];
  logic             dv_cl_nxt  [0:DIV_BITS];

  logic signed [CW-1:0] cx_r [0:CS];
  logic signed [CW-1:0] cy_r [0:CS];
  logic [ANG_W-1:0]     cz_r [0:CS];
  logic signed [CW-1:0] cx_nxt [0:CS];
  logic signed [CW-1:0] cy_nxt [0:CS];
  logic [ANG_W-1:0]     cz_nxt [0:CS];

  logic [2:0]        hs_sec_r [0:DH];
  logic [ANG_W:0]    hs_fm_r  [0:DH];
  logic [2:0]        hs_sec_nxt;
  logic [ANG_W:0]    hs_fm_nxt;

  logic [Q16_W-1:0]  s_r, s_nxt;
  logic [Q16_W-1:0]  x_r;
  logic [2:0]        sec_r;
  logic [Q16_W+ANG_W:0] prod;

  logic [7:0] red_r, green_r, blue_r, red_nxt, green_nxt, blue_nxt;

  // the last stage is the output register; everything moves together
  assign adv      = !vld_r[LAST] || out_ready;
  assign in_ready = adv;

  function automatic logic [7:0] to_byte(input logic [Q16_W-1:0] q);
    logic [Q16_W+8:0] acc;
    acc = ({q, 8'd0} - (Q16_W+9)'(q)) + (Q16_W+9)'(32768);
    return acc[23:16];
  endfunction

  always_comb begin
    logic [REMW-1:0]       tmp;
    logic [REMW-1:0]       trial;
    logic [DVW-1:0]        dsh;
    logic [DVW-1:0]        num;
    logic signed [CW-1:0]  xs, ys, xe, ye;
    logic [ANG_W+2:0]      p;
    logic [Q16_W-1:0]      rq, gq, bq;

    // squares of the components
    usq_s   = u0_r * u0_r;
    vsq_s   = v0_r * v0_r;
    usq_nxt = usq_s;
    vsq_nxt = vsq_s;

    // square root, one result bit per stage
    is_rad_nxt[0] = usq_r + vsq_r;
    is_rem_nxt[0] = '0;
    is_q_nxt[0]   = '0;
    for (int k = 0; k < FW; k++) begin
      tmp   = {is_rem_r[k][REMW-3:0], is_rad_r[k][RADW-1 -: 2]};
      trial = {is_q_r[k], 2'b01};
      is_rad_nxt[k+1] = is_rad_r[k] << 2;
      if (tmp >= trial) begin
        is_rem_nxt[k+1] = tmp - trial;
        is_q_nxt[k+1]   = {is_q_r[k][FW-2:0], 1'b1};
      end else begin
        is_rem_nxt[k+1] = tmp;
        is_q_nxt[k+1]   = {is_q_r[k][FW-2:0], 1'b0};
      end
    end

    // saturation divider: flag quotients past the clamp, then one bit a stage
    num           = DVW'(is_q_r[FW]) << SH;
    dv_rem_nxt[0] = num;
    dv_q_nxt[0]   = '0;
    dv_cl_nxt[0]  = num >= (DVW'(mdsq_r) << DIV_BITS);
    for (int j = 0; j < DIV_BITS; j++) begin
      dsh = DVW'(mdsq_r) << (DIV_BITS - 1 - j);
      dv_cl_nxt[j+1] = dv_cl_r[j];
      if (dv_rem_r[j] >= dsh) begin
        dv_rem_nxt[j+1] = dv_rem_r[j] - dsh;
        dv_q_nxt[j+1]   = {dv_q_r[j][Q16_W-2:0], 1'b1};
      end else begin
        dv_rem_nxt[j+1] = dv_rem_r[j];
        dv_q_nxt[j+1]   = {dv_q_r[j][Q16_W-2:0], 1'b0};
      end
    end

    // CORDIC: fold the left half plane over, then rotate toward the x axis
    xe = CW'(u0_r) <<< PRE_SH;
    ye = CW'(v0_r) <<< PRE_SH;
    if (u0_r < 0) begin
      cx_nxt[0] = -xe;
      cy_nxt[0] = -ye;
      cz_nxt[0] = HALF_TURN;
    end else begin
      cx_nxt[0] = xe;
      cy_nxt[0] = ye;
      cz_nxt[0] = '0;
    end
    for (int i = 0; i < CS; i++) begin
      xs = cx_r[i] >>> i;
      ys = cy_r[i] >>> i;
      if (cy_r[i] > 0) begin
        cx_nxt[i+1] = cx_r[i] + ys;
        cy_nxt[i+1] = cy_r[i] - xs;
        cz_nxt[i+1] = cz_r[i] + TURN_ATAN[i];
      end else begin
        cx_nxt[i+1] = cx_r[i] - ys;
        cy_nxt[i+1] = cy_r[i] + xs;
        cz_nxt[i+1] = cz_r[i] - TURN_ATAN[i];
      end
    end

    // sector and in-sector fraction; odd sectors run the fraction backward
    p = {1'b0, cz_r[CS], 2'b00} + {2'b00, cz_r[CS], 1'b0};
    hs_sec_nxt = p[ANG_W+2:ANG_W];
    if (hs_sec_nxt[0]) begin
      hs_fm_nxt = {1'b1, {ANG_W{1'b0}}} - {1'b0, p[ANG_W-1:0]};
    end else begin
      hs_fm_nxt = {1'b0, p[ANG_W-1:0]};
    end

    // clamp saturation to one
    s_nxt = (dv_cl_r[DIV_BITS] || dv_q_r[DIV_BITS] > Q16_ONE) ? Q16_ONE : dv_q_r[DIV_BITS];
    prod  = s_nxt * hs_fm_r[DH];

    // channel select and byte rounding
    case (sec_r)
      SEC_RY:  begin rq = s_r; gq = x_r; bq = '0;  end
      SEC_YG:  begin rq = x_r; gq = s_r; bq = '0;  end
      SEC_GC:  begin rq = '0;  gq = s_r; bq = x_r; end
      SEC_CB:  begin rq = '0;  gq = x_r; bq = s_r; end
      SEC_BM:  begin rq = x_r; gq = '0;  bq = s_r; end
      default: begin rq = s_r; gq = '0;  bq = x_r; end
    endcase
    if (pv_r[LAST-1]) begin
      red_nxt   = to_byte(rq);
      green_nxt = to_byte(gq);
      blue_nxt  = to_byte(bq);
    end else begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_disp_r <= MAX_DISP_RST;
      for (int n = 0; n <= LAST; n++) vld_r[n] <= 1'b0;
    end else begin
      max_disp_r <= max_disp_nxt;
      if (adv) begin
        vld_r[0] <= in_valid;
        for (int n = 1; n <= LAST; n++) vld_r[n] <= vld_r[n-1];
      end
    end
  end

  // payload: advance all stages on adv, hold otherwise
  always_ff @(posedge clk) begin
    mdsq_r <= mdsq_nxt;
    if (adv) begin
      u0_r     <= in_flow_u;
      v0_r     <= in_flow_v;
      pv_r[0]  <= in_pixel_valid;
      for (int n = 1; n <= LAST; n++) pv_r[n] <= pv_r[n-1];
      usq_r    <= usq_nxt;
      vsq_r    <= vsq_nxt;
      is_rad_r <= is_rad_nxt;
      is_rem_r <= is_rem_nxt;
      is_q_r   <= is_q_nxt;
      dv_rem_r <= dv_rem_nxt;
      dv_q_r   <= dv_q_nxt;
      dv_cl_r  <= dv_cl_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      cz_r     <= cz_nxt;
      hs_sec_r[0] <= hs_sec_nxt;
      hs_fm_r[0]  <= hs_fm_nxt;
      for (int d = 1; d <= DH; d++) begin
        hs_sec_r[d] <= hs_sec_r[d-1];
        hs_fm_r[d]  <= hs_fm_r[d-1];
      end
      s_r     <= s_nxt;
      x_r     <= prod[Q16_W+ANG_W-1:ANG_W];
      sec_r   <= hs_sec_r[DH];
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = vld_r[LAST];
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // ---------------------------------------------------------------- checks
  a_fold_right: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> cx_r[0] >= 0)
    else $error("CORDIC start vector left of the y axis");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST-1] |-> sec_r <= SEC_BM + 3'd1)
    else $error("hue sector out of range");

  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST-1] |-> s_r <= Q16_ONE && x_r <= s_r)
    else $error("saturation or mixed channel past one");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld_r[LAST] && $stable(sec_r) && $stable(s_r))
    else $error("pipeline moved during a stall");

endmodule
`default_nettype wire
